### hdl/brb_pkg.sv
// Shared types and constants for the byte ring buffer.
// Depends on nothing; imported by the top level and the port checker.
package brb_pkg;

    localparam int BRB_CAPACITY = 256;

    // Operation codes carried in the kind field.
    typedef enum logic [2:0] {
        KIND_PUSH    = 3'd0,
        KIND_POP     = 3'd1,
        KIND_PEEK    = 3'd2,
        KIND_ADVANCE = 3'd3,
        KIND_CLEAR   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] write_byte;
        logic [7:0] amount;
    } t_op_in;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       accepted;
        logic [7:0] used_count;
    } t_op_out;

endpackage

### hdl/byte_ring_buffer_top.sv
// Byte ring buffer top level: pointers, byte store and result pipeline.
// Depends on brb_pkg.
//
// Byte FIFO with head/tail pointers over a CAPACITY-entry store, one slot
// always kept free. One operation transaction (push, pop, peek, advance
// tail, clear pointers) is accepted per clock while o_op_ready is high,
// and each produces exactly one result transaction carrying the used
// count after the operation. Each result passes the stage 1 and output
// registers before result valid; throughput is one transaction per cycle
// unless stalled, set by the pointer update and the one read port of the
// store. After reset a clearing pass zeroes the store with o_op_ready low.
module byte_ring_buffer_top #(
    parameter int CAPACITY = brb_pkg::BRB_CAPACITY
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_op_valid,
    output logic            o_op_ready,
    input  brb_pkg::t_op_in i_op,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output brb_pkg::t_op_out o_res
);
    import brb_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int EXT_W = (PTR_W > 8) ? PTR_W : 8;
    localparam logic [PTR_W:0]   CAP_X = (PTR_W + 1)'(CAPACITY);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(CAPACITY - 1);

    typedef logic [PTR_W-1:0] t_ptr;
    typedef t_ptr t_mod_tbl [256];

    // amount modulo CAPACITY, built at elaboration
    function automatic t_mod_tbl f_mod_tbl();
        t_mod_tbl tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = PTR_W'(i % CAPACITY);
        end
        return tbl;
    endfunction

    localparam t_mod_tbl AMT_MOD = f_mod_tbl();

    // sum below 2*CAPACITY folded back into range
    function automatic t_ptr f_wrap(input logic [PTR_W:0] s);
        logic [PTR_W:0] d;
        d = s - CAP_X;
        return (s >= CAP_X) ? d[PTR_W-1:0] : s[PTR_W-1:0];
    endfunction

    function automatic t_ptr f_next(input t_ptr p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic t_ptr f_used(input t_ptr h, input t_ptr t);
        logic [PTR_W:0] d;
        d = {1'b0, h} - {1'b0, t};
        if (h < t) begin
            d = d + CAP_X;
        end
        return d[PTR_W-1:0];
    endfunction

    // pointers and control
    t_ptr r_head, r_tail, n_head, n_tail;
    t_ptr r_clr_idx;
    logic r_clearing;
    logic r_s1_valid;
    logic r_out_valid;

    // stage 1 payload
    logic       r_s1_is_read;
    logic       r_s1_acc;
    logic [7:0] r_s1_used;
    logic [7:0] r_rd_data;
    t_op_out    r_out;

    // byte store
    logic [7:0] r_store [CAPACITY];

    logic       accept;
    logic       out_free;
    logic       wr_en;
    logic       is_read;
    logic       acc;
    t_ptr       rd_addr;
    t_ptr       cur_used;
    t_ptr       step;
    t_ptr       n_used;
    logic [EXT_W-1:0] amount_ext;
    logic [EXT_W-1:0] used_ext;
    logic [EXT_W-1:0] n_used_ext;

    assign out_free   = !r_out_valid || i_res_ready;
    assign o_op_ready = !r_clearing && (!r_s1_valid || out_free);
    assign accept     = i_op_valid && o_op_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        cur_used   = f_used(r_head, r_tail);
        amount_ext = EXT_W'(i_op.amount);
        used_ext   = EXT_W'(cur_used);
        // advance never passes the head
        step       = (amount_ext < used_ext) ? amount_ext[PTR_W-1:0] : cur_used;

        n_head  = r_head;
        n_tail  = r_tail;
        rd_addr = r_tail;
        wr_en   = 1'b0;
        acc     = 1'b0;
        is_read = 1'b0;

        unique case (i_op.kind)
            KIND_PUSH: begin
                // dropped when full
                if (f_next(r_head) != r_tail) begin
                    wr_en  = 1'b1;
                    n_head = f_next(r_head);
                    acc    = 1'b1;
                end
            end
            KIND_POP: begin
                if (r_head != r_tail) begin
                    is_read = 1'b1;
                    acc     = 1'b1;
                    n_tail  = f_next(r_tail);
                end
            end
            KIND_PEEK: begin
                // no check against the used count
                rd_addr = f_wrap({1'b0, r_tail} + {1'b0, AMT_MOD[i_op.amount]});
                is_read = 1'b1;
            end
            KIND_ADVANCE: begin
                n_tail = f_wrap({1'b0, r_tail} + {1'b0, step});
            end
            KIND_CLEAR: begin
                n_head = '0;
                n_tail = '0;
            end
            default: begin
            end
        endcase

        n_used     = f_used(n_head, n_tail);
        n_used_ext = EXT_W'(n_used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_clr_idx   <= '0;
            r_clearing  <= 1'b1;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                r_head <= n_head;
                r_tail <= n_tail;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_is_read <= is_read;
            r_s1_acc     <= acc;
            r_s1_used    <= n_used_ext[7:0];
        end
        if (out_free && r_s1_valid) begin
            r_out.read_byte  <= r_s1_is_read ? r_rd_data : 8'h00;
            r_out.accepted   <= r_s1_acc;
            r_out.used_count <= r_s1_used;
        end
    end

    // store: cleared after reset, then one write and one read per accepted cycle
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_store[r_clr_idx] <= 8'h00;
        end else if (accept && wr_en) begin
            r_store[r_head] <= i_op.write_byte;
        end
        if (accept) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

endmodule

### hdl/brb_checker.sv
// Port-level checks for the byte ring buffer, bound to the top level.
// Depends on brb_pkg and byte_ring_buffer_top.
module brb_checker #(
    parameter int CAPACITY = brb_pkg::BRB_CAPACITY
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_op_valid,
    input logic             o_op_ready,
    input brb_pkg::t_op_in  i_op,
    input logic             o_res_valid,
    input logic             i_res_ready,
    input brb_pkg::t_op_out o_res
);
    import brb_pkg::*;

    logic in_acc;
    assign in_acc = i_op_valid && o_op_ready;

    // reset starts the clearing pass and empties the result path
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_op_ready && !o_res_valid)
        else $error("ready or result valid right after reset");

    // a fresh result comes from an operation taken before it, via stage 1
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(in_acc, 2))
        else $error("result without matching operation");

    // one slot stays free
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (CAPACITY > 256) || (32'(o_res.used_count) < CAPACITY))
        else $error("used count out of range");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("stalled result changed");

endmodule

bind byte_ring_buffer_top brb_checker #(.CAPACITY(CAPACITY)) u_brb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_op_valid  (i_op_valid),
    .o_op_ready  (o_op_ready),
    .i_op        (i_op),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_res       (o_res)
);

### sim/byte_ring_buffer_top_tb.sv
// Self-checking testbench for byte_ring_buffer_top: random and directed operation traffic
// with result prediction. Depends on brb_pkg and byte_ring_buffer_top only.
module byte_ring_buffer_top_tb;

    import brb_pkg::*;

    localparam int CAP          = BRB_CAPACITY;
    localparam int CLK_HALF     = 5;
    localparam int LIMIT_CYCLES = 400_000;   // hard stop for a hung run
    localparam int DRAIN_CYCLES = 16;        // margin for the results still in the pipeline
    localparam int HOLD_CYCLES  = 300;       // long result stall to back up the input
    localparam int MAX_REPORTS  = 10;
    localparam int N_KIND_CODES = 8;         // full range of the 3-bit kind field
    localparam int GAP_MAX      = 17;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_op_valid;
    logic     o_op_ready;
    t_op_in   i_op;
    logic     o_res_valid;
    logic     i_res_ready;
    t_op_out  o_res;

    byte_ring_buffer_top #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (i_op_valid),
        .o_op_ready (o_op_ready),
        .i_op       (i_op),
        .o_res_valid(o_res_valid),
        .i_res_ready(i_res_ready),
        .o_res      (o_res)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ring state mirror: pointers and byte store, updated on every
    // accepted operation transaction.
    // ------------------------------------------------------------------
    int unsigned ring_head;
    int unsigned ring_tail;
    logic [7:0]  ring_mem [CAP];

    // Expected result transactions, oldest first.
    t_op_out     result_q [$];
    t_op_out     due_res;

    // Traffic shaping controls for the sender and the receiver process.
    bit          tx_gaps_on;
    bit          rx_gaps_on;
    bit          rx_hold_req;

    // Bookkeeping.
    int          n_bad;
    int          n_checked;
    int          n_kind [N_KIND_CODES];
    int          n_push_dropped;
    int          n_pop_empty;

    function automatic int unsigned ring_used();
        if (ring_head >= ring_tail) begin
            return ring_head - ring_tail;
        end
        return CAP - (ring_tail - ring_head);
    endfunction

    function automatic void ring_reset();
        ring_head = 0;
        ring_tail = 0;
        foreach (ring_mem[i]) ring_mem[i] = 8'h00;
    endfunction

    // Applies one operation to the mirror and returns the result it must produce.
    function automatic t_op_out ring_apply(t_op_in op);
        t_op_out     r;
        int unsigned nxt;
        int unsigned used;
        int unsigned adv;
        r = '0;
        n_kind[op.kind]++;
        case (op.kind)
            KIND_PUSH: begin
                nxt = (ring_head + 1) % CAP;
                if (nxt != ring_tail) begin
                    ring_mem[ring_head] = op.write_byte;
                    ring_head = nxt;
                    r.accepted = 1'b1;
                end else begin
                    n_push_dropped++;      // full: byte silently lost
                end
            end
            KIND_POP: begin
                if (ring_head != ring_tail) begin
                    r.read_byte = ring_mem[ring_tail];
                    ring_tail = (ring_tail + 1) % CAP;
                    r.accepted = 1'b1;
                end else begin
                    n_pop_empty++;
                end
            end
            KIND_PEEK: begin
                // no bound check against the used count: stale bytes are fair game
                r.read_byte = ring_mem[(ring_tail + op.amount) % CAP];
            end
            KIND_ADVANCE: begin
                used = ring_used();
                adv = (op.amount < used) ? op.amount : used;
                ring_tail = (ring_tail + adv) % CAP;
            end
            KIND_CLEAR: begin
                ring_head = 0;     // store contents survive
                ring_tail = 0;
            end
            default: ;             // unused codes do nothing
        endcase
        r.used_count = 8'(ring_used());
        return r;
    endfunction

    function automatic t_op_in make_op(logic [2:0] kind, logic [7:0] wb, logic [7:0] amt);
        t_op_in op;
        op.kind       = kind;
        op.write_byte = wb;
        op.amount     = amt;
        return op;
    endfunction

    // Weighted random operation; payload fields outside the kind are always random.
    function automatic t_op_in rand_op();
        int         pick;
        logic [2:0] kind;
        logic [7:0] amt;
        pick = $urandom_range(0, 99);
        amt  = 8'($urandom);
        if (pick < 40) begin
            kind = KIND_PUSH;
        end else if (pick < 70) begin
            kind = KIND_POP;
        end else if (pick < 85) begin
            kind = KIND_PEEK;
            if ($urandom_range(0, 1) == 0) amt = 8'($urandom_range(0, 15));
        end else if (pick < 92) begin
            kind = KIND_ADVANCE;
            if ($urandom_range(0, 3) != 0) amt = 8'($urandom_range(0, 7));
        end else if (pick < 96) begin
            kind = KIND_CLEAR;
        end else begin
            kind = 3'($urandom_range(int'(KIND_CLEAR) + 1, N_KIND_CODES - 1));
        end
        return make_op(kind, 8'($urandom), amt);
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one transaction, hold it until accepted, predict.
    // Valid is left high when no gap follows, so back-to-back calls keep
    // it asserted; callers that pause must go through tx_stop().
    // ------------------------------------------------------------------
    task automatic issue_op(input t_op_in op);
        i_op_valid <= 1'b1;
        i_op       <= op;
        do @(posedge i_clk); while (o_op_ready !== 1'b1);
        result_q.push_back(ring_apply(op));
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            i_op_valid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge i_clk);
        end
    endtask

    task automatic tx_stop();
        i_op_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        tx_stop();
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold on request.
    // ------------------------------------------------------------------
    initial begin
        i_res_ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (rx_hold_req) begin
                i_res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_gaps_on && $urandom_range(0, 9) == 0) begin
                i_res_ready <= 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(posedge i_clk);
            end else begin
                i_res_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every result transaction against the oldest
    // expectation, all three fields.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_res_valid === 1'b1 && i_res_ready === 1'b1) begin
            if (result_q.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS) begin
                    $display("%0t: unexpected result read_byte=%h accepted=%b used_count=%0d",
                             $time, o_res.read_byte, o_res.accepted, o_res.used_count);
                end
            end else begin
                due_res = result_q.pop_front();
                n_checked++;
                if (o_res.read_byte !== due_res.read_byte
                        || o_res.accepted !== due_res.accepted
                        || o_res.used_count !== due_res.used_count) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS) begin
                        $display("%0t: result %0d mismatch: exp byte=%h acc=%b used=%0d",
                                 $time, n_checked, due_res.read_byte, due_res.accepted,
                                 due_res.used_count);
                        $display("%0t:                      got byte=%h acc=%b used=%0d",
                                 $time, o_res.read_byte, o_res.accepted, o_res.used_count);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty-buffer behavior, field extremes, far peek, bounded
    // advance, clear keeping stale bytes, and the unused kind codes.
    task automatic test_directed_cases();
        issue_op(make_op(KIND_POP,     8'h00, 8'h00));   // pop on empty
        issue_op(make_op(KIND_PEEK,    8'h00, 8'hFF));   // peek far, store still zero
        issue_op(make_op(KIND_ADVANCE, 8'hFF, 8'hFF));   // advance on empty goes nowhere
        issue_op(make_op(KIND_PUSH,    8'h00, 8'h00));
        issue_op(make_op(KIND_PUSH,    8'hFF, 8'hFF));
        issue_op(make_op(KIND_PUSH,    8'h5A, 8'h00));
        issue_op(make_op(KIND_PEEK,    8'h00, 8'h00));
        issue_op(make_op(KIND_PEEK,    8'h00, 8'h02));
        issue_op(make_op(KIND_PEEK,    8'h00, 8'hFF));   // far peek to the last entry, no wrap
        issue_op(make_op(KIND_POP,     8'hFF, 8'hFF));
        issue_op(make_op(KIND_ADVANCE, 8'h00, 8'hFF));   // clipped to the used count
        issue_op(make_op(KIND_POP,     8'h00, 8'h00));   // empty again
        issue_op(make_op(KIND_PUSH,    8'hA5, 8'h00));
        issue_op(make_op(KIND_PUSH,    8'h3C, 8'h00));
        issue_op(make_op(KIND_ADVANCE, 8'h00, 8'h01));
        issue_op(make_op(KIND_CLEAR,   8'hFF, 8'hFF));
        issue_op(make_op(KIND_PEEK,    8'h00, 8'h03));   // stale byte after clear
        issue_op(make_op(KIND_POP,     8'h00, 8'h00));
        for (int k = int'(KIND_CLEAR) + 1; k < N_KIND_CODES; k++) begin
            issue_op(make_op(3'(k), 8'hFF, 8'hFF));
        end
        issue_op(make_op(KIND_PUSH,    8'h81, 8'h00));
        issue_op(make_op(KIND_POP,     8'h00, 8'h00));
    endtask

    // Fill to the one-free-slot limit and push past it, then peek, advance
    // and pop, and push again so that the head wraps past the end.
    task automatic test_fill_past_full();
        issue_op(make_op(KIND_CLEAR, 8'($urandom), 8'($urandom)));
        repeat (CAP + 1) issue_op(make_op(KIND_PUSH, 8'($urandom), 8'($urandom)));
        repeat (10) issue_op(make_op(KIND_PEEK, 8'($urandom), 8'($urandom)));
        issue_op(make_op(KIND_ADVANCE, 8'($urandom), 8'($urandom)));
        repeat (20) issue_op(make_op(KIND_POP, 8'($urandom), 8'($urandom)));
        repeat (10) issue_op(make_op(KIND_PUSH, 8'($urandom), 8'($urandom)));
    endtask

    task automatic test_random_ops(input int count);
        repeat (count) issue_op(rand_op());
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the pipeline backs up and o_op_ready drops.
    task automatic test_output_backpressure();
        rx_hold_req = 1'b1;
        repeat (40) issue_op(rand_op());
        tx_stop();
        while (rx_hold_req) @(posedge i_clk);
    endtask

    // Sender goes quiet until every outstanding result has come back, then resumes.
    task automatic test_sender_pause();
        wait_drained();
        test_random_ops(20);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_op_valid  <= 1'b0;
        i_op        <= '0;
        tx_gaps_on  = 1'b1;
        rx_gaps_on  = 1'b1;
        rx_hold_req = 1'b0;
        n_bad       = 0;
        n_checked   = 0;
        n_push_dropped = 0;
        n_pop_empty = 0;
        foreach (n_kind[i]) n_kind[i] = 0;
        ring_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the store clearing pass after reset is absorbed by the handshake
        test_directed_cases();
        test_fill_past_full();
        test_random_ops(330);
        test_output_backpressure();
        test_sender_pause();

        // last stretch at full rate on both sides
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        test_random_ops(100);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: push %0d (%0d dropped full), pop %0d (%0d empty),",
                 n_checked, n_kind[KIND_PUSH], n_push_dropped, n_kind[KIND_POP], n_pop_empty);
        $display("peek %0d, advance %0d, clear %0d, unused codes %0d; %0d mismatches.",
                 n_kind[KIND_PEEK], n_kind[KIND_ADVANCE], n_kind[KIND_CLEAR],
                 n_kind[5] + n_kind[6] + n_kind[7], n_bad);
        if (n_bad == 0 && result_q.size() == 0) begin
            $display("** byte_ring_buffer_top: PASSED **");
        end else begin
            $display("** byte_ring_buffer_top: FAILED **");
        end
        $finish;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("timeout with %0d results outstanding", result_q.size());
        $display("** byte_ring_buffer_top: FAILED **");
        $finish;
    end

endmodule

### sim.f
hdl/brb_pkg.sv
hdl/byte_ring_buffer_top.sv
hdl/brb_checker.sv
sim/byte_ring_buffer_top_tb.sv
